// ===== rtl/sf32_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the simplified single-precision float unit.
package sf32_pkg;

	typedef enum logic [3:0] {
		KIND_ADD   = 4'd0,
		KIND_SUB   = 4'd1,
		KIND_MUL   = 4'd2,
		KIND_DIV   = 4'd3,
		KIND_EQ    = 4'd4,
		KIND_NE    = 4'd5,
		KIND_LT    = 4'd6,
		KIND_LE    = 4'd7,
		KIND_ITOF  = 4'd8,
		KIND_FTOI  = 4'd9,
		KIND_FMAG  = 4'd10
	} kind_t;

	localparam logic [31:0] SGN_BIT = 32'h8000_0000;
	localparam logic [31:0] FRAC_M  = 32'h007f_ffff;
	localparam logic [31:0] INF_EXP = 32'h7f80_0000;
	localparam logic [31:0] MAG_M   = 32'h7fff_ffff;
	localparam logic [7:0]  BIAS    = 8'd127;

	// Request to the normalize-and-pack stages. A bypass carries a finished word.
	typedef struct packed {
		logic               bypass;
		logic [31:0]        bypass_val;
		logic               neg;
		logic signed [10:0] exp;
		logic [31:0]        mant;
	} pack_req_t;

endpackage

// ===== rtl/sf32_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for operation requests and results.
interface sf32_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [31:0] operand_a;
	logic [31:0] operand_b;

	modport source (output valid, kind, operand_a, operand_b, input ready);
	modport sink (input valid, kind, operand_a, operand_b, output ready);
endinterface

interface sf32_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result;

	modport source (output valid, result, input ready);
	modport sink (input valid, result, output ready);
endinterface

// ===== rtl/simplified_f32_alu_top.sv =====
`timescale 1ns / 1ps
// Top level of the simplified single-precision float unit.
//
// Requests arrive on req (kind, operand_a, operand_b); each yields exactly one
// 32-bit word on rsp. Add, sub, mul, div, compares and conversions all share
// one five-stage pipeline. Throughput is one request per cycle while the
// receiver does not stall. Division is spread as three quotient bits in
// each of the first three stages; normalization takes the last two.
// The whole pipeline advances together: when the last stage holds a result
// that rsp does not take, every stage holds and req.ready drops, so nothing
// is lost or repeated. req.ready is high whenever the last stage is empty or
// is being drained, so a stalled receiver costs no bubbles once it resumes.
// Reset clears all valid bits; the unit keeps no other state.
// Kinds above float_magnitude give a result of zero.
module simplified_f32_alu_top (
	input  logic        clk,
	input  logic        arst_n,
	sf32_req_if.sink    req,
	sf32_rsp_if.source  rsp
);

	logic en;
	assign en        = !rsp.valid || rsp.ready;
	assign req.ready = en;

	// Three restoring division steps, quotient bits hi down to hi-2.
	function automatic logic [32:0] div3(input logic [23:0] rem, input logic [8:0] q,
			input logic [15:0] dvs, input logic [3:0] hi);
		logic [23:0] r;
		logic [8:0]  qq;
		logic [23:0] cmp;
		logic [3:0]  idx;
		r  = rem;
		qq = q;
		for (int k = 0; k < 3; k++) begin
			idx = hi - k[3:0];
			cmp = {8'b0, dvs} << idx;
			if (r >= cmp) begin
				r = r - cmp;
				qq[idx] = 1'b1;
			end
		end
		return {r, qq};
	endfunction

	// ---------------- stage 1: unpack, align, compare, first divide bits
	logic [3:0]  kind;
	logic [31:0] a;
	logic [31:0] b;
	logic        za, zb, sa, sb;
	logic [7:0]  ea, eb;
	logic [23:0] ma, mb;
	logic        eq, lt;
	logic [31:0] key_a, key_b;
	logic [54:0] mag_sh;
	logic [31:0] mag;
	logic [32:0] dstep0;

	logic        bypass_c1;
	logic [31:0] bval_c1;
	logic signed [10:0] exp_c1;
	logic [31:0] opa_c1, opb_c1;
	logic [23:0] rem_c1;
	logic [8:0]  q_c1;

	logic               v_s1;
	logic [3:0]         kind_s1;
	logic               bypass_s1;
	logic [31:0]        bval_s1;
	logic               sa_s1, sb_s1;
	logic signed [10:0] exp_s1;
	logic [31:0]        opa_s1, opb_s1;
	logic [23:0]        rem_s1;
	logic [8:0]         q_s1;

	always_comb begin
		kind = req.kind;
		a    = req.operand_a;
		b    = (kind == sf32_pkg::KIND_SUB) ? (req.operand_b ^ sf32_pkg::SGN_BIT)
		                                     : req.operand_b;
		za = (a & sf32_pkg::MAG_M) == '0;
		zb = (b & sf32_pkg::MAG_M) == '0;
		sa = a[31];
		sb = b[31];
		ea = a[30:23];
		eb = b[30:23];
		ma = {1'b1, a[22:0]};
		mb = {1'b1, b[22:0]};

		eq    = (za && zb) || (a == b);
		key_a = a[31] ? ~a : (a | sf32_pkg::SGN_BIT);
		key_b = b[31] ? ~b : (b | sf32_pkg::SGN_BIT);
		lt    = !eq && (key_a < key_b);

		mag_sh = {31'b0, ma} << ea[4:0] - sf32_pkg::BIAS[4:0];
		if (za || ea < sf32_pkg::BIAS) begin
			mag = '0;
		end else if (ea > 8'd157) begin
			mag = sf32_pkg::MAG_M;
		end else begin
			mag = mag_sh[54:23];
		end

		dstep0 = div3(ma, 9'b0, mb[23:8], 4'd8);

		bypass_c1 = 1'b1;
		bval_c1   = '0;
		exp_c1    = '0;
		opa_c1    = '0;
		opb_c1    = '0;
		rem_c1    = dstep0[32:9];
		q_c1      = dstep0[8:0];

		unique case (kind)
			sf32_pkg::KIND_ADD, sf32_pkg::KIND_SUB: begin
				if (za) begin
					bval_c1 = b;
				end else if (zb) begin
					bval_c1 = a;
				end else begin
					bypass_c1 = 1'b0;
					if (ea > eb) begin
						exp_c1 = $signed({3'b0, ea});
						opa_c1 = {8'b0, ma};
						opb_c1 = {8'b0, mb >> (ea - eb)};
					end else begin
						exp_c1 = $signed({3'b0, eb});
						opa_c1 = {8'b0, ma >> (eb - ea)};
						opb_c1 = {8'b0, mb};
					end
				end
			end
			sf32_pkg::KIND_MUL: begin
				if (!(za || zb)) begin
					bypass_c1 = 1'b0;
					exp_c1 = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd134;
					opa_c1 = {16'b0, ma[23:8]};
					opb_c1 = {16'b0, mb[23:8]};
				end
			end
			sf32_pkg::KIND_DIV: begin
				if (!za) begin
					if (zb) begin
						bval_c1 = ((a ^ b) & sf32_pkg::SGN_BIT) | sf32_pkg::INF_EXP;
					end else begin
						bypass_c1 = 1'b0;
						exp_c1 = $signed({3'b0, ea}) - $signed({3'b0, eb}) + 11'sd142;
						opb_c1 = {16'b0, mb[23:8]};
					end
				end
			end
			sf32_pkg::KIND_EQ: bval_c1 = {31'b0, eq};
			sf32_pkg::KIND_NE: bval_c1 = {31'b0, !eq};
			sf32_pkg::KIND_LT: bval_c1 = {31'b0, lt};
			sf32_pkg::KIND_LE: bval_c1 = {31'b0, eq || lt};
			sf32_pkg::KIND_ITOF: begin
				bypass_c1 = 1'b0;
				exp_c1 = 11'sd150;
				opa_c1 = a[31] ? (32'd0 - a) : a;
			end
			sf32_pkg::KIND_FTOI: bval_c1 = a[31] ? (32'd0 - mag) : mag;
			sf32_pkg::KIND_FMAG: bval_c1 = mag;
			default: bval_c1 = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1   <= kind;
			bypass_s1 <= bypass_c1;
			bval_s1   <= bval_c1;
			sa_s1     <= sa;
			sb_s1     <= sb;
			exp_s1    <= exp_c1;
			opa_s1    <= opa_c1;
			opb_s1    <= opb_c1;
			rem_s1    <= rem_c1;
			q_s1      <= q_c1;
		end
	end

	// ---------------- stage 2: add/sub, multiply, middle divide bits
	logic [32:0]        dstep1;
	logic               neg_c2;
	logic [31:0]        mant_c2;

	logic               v_s2;
	logic [3:0]         kind_s2;
	logic               bypass_s2;
	logic [31:0]        bval_s2;
	logic               neg_s2;
	logic signed [10:0] exp_s2;
	logic [31:0]        mant_s2;
	logic [15:0]        dvs_s2;
	logic [23:0]        rem_s2;
	logic [8:0]         q_s2;

	always_comb begin
		dstep1  = div3(rem_s1, q_s1, opb_s1[15:0], 4'd5);
		neg_c2  = sa_s1 ^ sb_s1;
		mant_c2 = '0;
		unique case (kind_s1)
			sf32_pkg::KIND_ADD, sf32_pkg::KIND_SUB: begin
				if (sa_s1 == sb_s1) begin
					neg_c2  = sa_s1;
					mant_c2 = opa_s1 + opb_s1;
				end else if (opa_s1 >= opb_s1) begin
					neg_c2  = sa_s1;
					mant_c2 = opa_s1 - opb_s1;
				end else begin
					neg_c2  = sb_s1;
					mant_c2 = opb_s1 - opa_s1;
				end
			end
			sf32_pkg::KIND_MUL: mant_c2 = {16'b0, opa_s1[15:0]} * {16'b0, opb_s1[15:0]};
			sf32_pkg::KIND_ITOF: begin
				neg_c2  = sa_s1;
				mant_c2 = opa_s1;
			end
			default: mant_c2 = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2   <= kind_s1;
			bypass_s2 <= bypass_s1;
			bval_s2   <= bval_s1;
			neg_s2    <= neg_c2;
			exp_s2    <= exp_s1;
			mant_s2   <= mant_c2;
			dvs_s2    <= opb_s1[15:0];
			rem_s2    <= dstep1[32:9];
			q_s2      <= dstep1[8:0];
		end
	end

	// ---------------- stage 3: last divide bits, hand off to packing
	logic [32:0]         dstep2;
	sf32_pkg::pack_req_t preq_c3;
	sf32_pkg::pack_req_t preq_s3;
	logic                v_s3;

	always_comb begin
		dstep2             = div3(rem_s2, q_s2, dvs_s2, 4'd2);
		preq_c3.bypass     = bypass_s2;
		preq_c3.bypass_val = bval_s2;
		preq_c3.neg        = neg_s2;
		preq_c3.exp        = exp_s2;
		preq_c3.mant       = (kind_s2 == sf32_pkg::KIND_DIV) ? {23'b0, dstep2[8:0]}
		                                                     : mant_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			preq_s3 <= preq_c3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// ---------------- stages 4 and 5: normalize and pack
	sf32_pack u_pack (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_s3),
		.req_in (preq_s3),
		.v_out  (rsp.valid),
		.result (rsp.result)
	);

	// ---------------- checks
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (rsp.valid && !rsp.ready))
		else $error("request side stalled while the result stage could drain");

	a_valid_advances: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> (v_s2 == $past(v_s1) && v_s3 == $past(v_s2)))
		else $error("valid bit lost or duplicated between stages");

	a_hold_keeps_stages: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> (v_s1 == $past(v_s1) && v_s3 == $past(v_s3) && rsp.valid))
		else $error("pipeline moved during a stall");

endmodule

// ===== rtl/sf32_pack.sv =====
`timescale 1ns / 1ps
// Two pipeline stages that normalize a mantissa and pack the float word.
module sf32_pack (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  v_in,
	input  sf32_pkg::pack_req_t   req_in,
	output logic                  v_out,
	output logic [31:0]           result
);

	logic               v_s4;
	logic               bypass_s4;
	logic [31:0]        bval_s4;
	logic               neg_s4;
	logic signed [10:0] exp_s4;
	logic [31:0]        mant_s4;
	logic [4:0]         msb_s4;
	logic               v_s5;
	logic [31:0]        res_s5;

	logic [4:0]         msb;
	logic [4:0]         shamt;
	logic [31:0]        mnorm;
	logic [31:0]        packed_word;

	always_comb begin
		msb = '0;
		for (int i = 0; i < 32; i++) begin
			if (req_in.mant[i]) begin
				msb = i[4:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_in;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bypass_s4 <= req_in.bypass;
			bval_s4   <= req_in.bypass_val;
			neg_s4    <= req_in.neg;
			mant_s4   <= req_in.mant;
			msb_s4    <= msb;
			// Final exponent once the leading one sits at bit 23.
			exp_s4    <= req_in.exp + $signed({6'b0, msb}) - 11'sd23;
			res_s5    <= packed_word;
		end
	end

	always_comb begin
		shamt = 5'd31 - msb_s4;
		mnorm = mant_s4 << shamt;
		if (bypass_s4) begin
			packed_word = bval_s4;
		end else if (mant_s4 == '0 || exp_s4 <= 11'sd0) begin
			packed_word = '0;
		end else if (exp_s4 >= 11'sd255) begin
			packed_word = {neg_s4, 31'b0} | sf32_pkg::INF_EXP;
		end else begin
			packed_word = {neg_s4, exp_s4[7:0], mnorm[30:8]};
		end
	end

	assign v_out  = v_s5;
	assign result = res_s5;

endmodule
